// ----- design/lfu_key_value_cache_defines.svh -----
// Assertion macros for the LFU key/value cache.
// Included by the top level; no other dependencies.
`ifndef LFU_KEY_VALUE_CACHE_DEFINES_SVH
`define LFU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFUKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu_key_value_cache: assertion failed");

// Next-cycle implication, disabled during reset.
`define LFUKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu_key_value_cache: assertion failed");

`endif

// ----- design/lfukv_pkg.sv -----
// Shared constants, types and helpers for the LFU key/value cache.
// No dependencies.
package lfukv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 5;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 16'h0001;
    localparam logic [VAL_W-1:0]   MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // sequencer -> scan unit
    typedef struct packed {
        logic start;      // clear accumulators
        logic beat;       // read data for one entry is present
        logic ent_valid;  // valid bit of that entry
    } scan_ctl_t;

    // scan unit -> sequencer
    typedef struct packed {
        logic found;
        logic vic_found;
        logic free_found;
    } scan_flags_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + COUNT_ONE;
    endfunction

endpackage

// ----- design/lfukv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lfukv_scan_unit.sv -----
// Scan unit: one entry per beat, key match, victim compare, fill count.
// Depends on lfukv_pkg.
module lfukv_scan_unit #(
    parameter int ENTRIES = lfukv_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int RW = IW,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfukv_pkg::scan_ctl_t          ctl,
    input  logic [IW-1:0]                 idx,
    input  logic [lfukv_pkg::KEY_W-1:0]   key_in,
    input  logic [lfukv_pkg::KEY_W-1:0]   key_rd,
    input  logic [lfukv_pkg::VAL_W-1:0]   val_rd,
    input  logic [lfukv_pkg::COUNT_W-1:0] cnt_rd,
    input  logic [RW-1:0]                 rank_rd,
    output lfukv_pkg::scan_flags_t        flags,
    output logic [IW-1:0]                 m_idx,
    output logic [lfukv_pkg::VAL_W-1:0]   m_val,
    output logic [lfukv_pkg::COUNT_W-1:0] m_cnt,
    output logic [RW-1:0]                 m_rank,
    output logic [IW-1:0]                 vic_idx,
    output logic [RW-1:0]                 vic_rank,
    output logic [IW-1:0]                 free_idx,
    output logic [CW-1:0]                 used
);
    import lfukv_pkg::*;

    scan_flags_t        flags_reg;
    logic [CW-1:0]      used_reg;
    logic [IW-1:0]      m_idx_reg;
    logic [VAL_W-1:0]   m_val_reg;
    logic [COUNT_W-1:0] m_cnt_reg;
    logic [RW-1:0]      m_rank_reg;
    logic [IW-1:0]      vic_idx_reg;
    logic [COUNT_W-1:0] vic_cnt_reg;
    logic [RW-1:0]      vic_rank_reg;
    logic [IW-1:0]      free_idx_reg;

    logic key_take;
    logic vic_take;
    logic free_take;

    // lowest count wins; on a tie the older (larger rank) entry wins
    assign key_take  = ctl.beat && ctl.ent_valid && !flags_reg.found && (key_rd == key_in);
    assign vic_take  = ctl.beat && ctl.ent_valid &&
                       (!flags_reg.vic_found || (cnt_rd < vic_cnt_reg) ||
                        ((cnt_rd == vic_cnt_reg) && (rank_rd > vic_rank_reg)));
    assign free_take = ctl.beat && !ctl.ent_valid && !flags_reg.free_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            used_reg  <= '0;
        end
        else if (ctl.start)
        begin
            flags_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            if (ctl.beat && ctl.ent_valid)
            begin
                used_reg <= used_reg + CW'(1);
            end
            if (key_take)
            begin
                flags_reg.found <= 1'b1;
            end
            if (vic_take)
            begin
                flags_reg.vic_found <= 1'b1;
            end
            if (free_take)
            begin
                flags_reg.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_take)
        begin
            m_idx_reg  <= idx;
            m_val_reg  <= val_rd;
            m_cnt_reg  <= cnt_rd;
            m_rank_reg <= rank_rd;
        end
        if (vic_take)
        begin
            vic_idx_reg  <= idx;
            vic_cnt_reg  <= cnt_rd;
            vic_rank_reg <= rank_rd;
        end
        if (free_take)
        begin
            free_idx_reg <= idx;
        end
    end

    assign flags    = flags_reg;
    assign used     = used_reg;
    assign m_idx    = m_idx_reg;
    assign m_val    = m_val_reg;
    assign m_cnt    = m_cnt_reg;
    assign m_rank   = m_rank_reg;
    assign vic_idx  = vic_idx_reg;
    assign vic_rank = vic_rank_reg;
    assign free_idx = free_idx_reg;

endmodule

// ----- design/lfu_key_value_cache.sv -----
// LFU key/value cache: command sequencer, entry memories, result register.
// Depends on lfukv_pkg, lfukv_ram, lfukv_scan_unit and the defines header.
//
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_data = capacity (reset 16).
//     Write only while the block is idle; cfg_ready is always high.
//   s channel: one beat per command. s_tuser = command (0 get, 1 set),
//     s_tdata = key, value. s_tready is high only while the sequencer idles.
//   m channel: one beat per get: hit flag and value (-1 on a miss).
//   Each command makes two passes over the entries through the single read
//   port of each memory: a scan pass (key match, LFU/LRU victim, fill count)
//   and a rank update pass. A get miss skips the update pass. With capacity
//   zero a command makes no pass: a set is dropped and a get returns a miss.
//   The result sits in an output register; a stalled receiver only holds
//   the block when a further get result is ready and the register is full.
//   Reset clears the valid bits (one flip-flop per entry) and the sequencer and
//   sets the capacity to 16; entry memories need no clearing pass.
`include "lfu_key_value_cache_defines.svh"

module lfu_key_value_cache #(
    parameter int ENTRIES = lfukv_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfukv_pkg::CFG_W-1:0]       cfg_data,   // capacity
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfukv_pkg::IN_TDATA_W-1:0]  s_tdata,    // key[31:0], value[63:32]
    input  logic [0:0]                        s_tuser,    // command[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lfukv_pkg::OUT_TDATA_W-1:0] m_tdata     // hit[0], read_value[32:1], zero
);
    import lfukv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      scan_reg;
    logic               rd_vld_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic [CFG_W-1:0]   cap_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IW-1:0]      tgt_reg;
    logic [RW-1:0]      thr_reg;
    logic               all_reg;
    logic               res_hit_reg;
    logic [VAL_W-1:0]   res_val_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [VAL_W-1:0]   out_val_reg;

    logic               in_beat;
    logic               issue;
    logic               last_beat;
    logic               cap_zero;
    logic               full;
    logic               out_free;

    logic [IW-1:0]      dec_tgt;
    logic [RW-1:0]      dec_thr;
    logic               dec_all;
    logic               dec_update;

    scan_ctl_t          sctl;
    scan_flags_t        sflags;
    logic [IW-1:0]      m_idx, vic_idx, free_idx;
    logic [VAL_W-1:0]   m_val;
    logic [COUNT_W-1:0] m_cnt;
    logic [RW-1:0]      m_rank, vic_rank;
    logic [CW-1:0]      used;

    logic [KEY_W-1:0]   key_rd;
    logic [VAL_W-1:0]   val_rd;
    logic [COUNT_W-1:0] cnt_rd;
    logic [RW-1:0]      rank_rd;
    logic               key_we, val_we, cnt_we, rank_we;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [RW-1:0]      rank_wdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cap_zero  = (cap_reg == '0);
    assign full      = (EW'(used) >= EW'(cap_reg)) || (used == CW'(ENTRIES));
    assign out_free  = !out_valid_reg || m_tready;

    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_UPD)) &&
                       (scan_reg != CW'(ENTRIES));
    assign last_beat = rd_vld_reg && (rd_idx_reg == IW'(ENTRIES - 1));

    // target of the update pass: hit entry, evicted victim, or free slot
    always_comb
    begin
        dec_tgt    = free_idx;
        dec_thr    = '0;
        dec_all    = 1'b1;
        dec_update = sflags.found || (cmd_reg == CMD_SET);
        if (sflags.found)
        begin
            dec_tgt = m_idx;
            dec_thr = m_rank;
            dec_all = 1'b0;
        end
        else if (full && sflags.vic_found)
        begin
            // evict then insert collapses to a touch of the victim slot
            dec_tgt = vic_idx;
            dec_thr = vic_rank;
            dec_all = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (!cap_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (s_tuser[0] == CMD_GET)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_beat)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = dec_update ? ST_UPD : ST_RESP;
            end
            ST_UPD:
            begin
                if (last_beat)
                begin
                    state_next = (cmd_reg == CMD_GET) ? ST_RESP : ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (in_beat || (state_reg == ST_DECIDE))
            begin
                scan_reg <= '0;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            if ((state_reg == ST_DECIDE) && dec_update)
            begin
                valid_reg[dec_tgt] <= 1'b1;
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg[IW-1:0];
        if (in_beat)
        begin
            cmd_reg     <= s_tuser[0];
            key_reg     <= s_tdata[KEY_W-1:0];
            val_reg     <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            res_hit_reg <= 1'b0;
            res_val_reg <= MISS_VALUE;
        end
        if (state_reg == ST_DECIDE)
        begin
            tgt_reg     <= dec_tgt;
            thr_reg     <= dec_thr;
            all_reg     <= dec_all;
            res_hit_reg <= sflags.found;
            res_val_reg <= sflags.found ? m_val : MISS_VALUE;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_hit_reg <= res_hit_reg;
            out_val_reg <= res_val_reg;
        end
    end

    assign sctl.start     = in_beat;
    assign sctl.beat      = rd_vld_reg && (state_reg == ST_SCAN);
    assign sctl.ent_valid = valid_reg[rd_idx_reg];

    lfukv_scan_unit #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sctl),
        .idx      (rd_idx_reg),
        .key_in   (key_reg),
        .key_rd   (key_rd),
        .val_rd   (val_rd),
        .cnt_rd   (cnt_rd),
        .rank_rd  (rank_rd),
        .flags    (sflags),
        .m_idx    (m_idx),
        .m_val    (m_val),
        .m_cnt    (m_cnt),
        .m_rank   (m_rank),
        .vic_idx  (vic_idx),
        .vic_rank (vic_rank),
        .free_idx (free_idx),
        .used     (used)
    );

    assign key_we    = (state_reg == ST_DECIDE) && (cmd_reg == CMD_SET) && !sflags.found;
    assign val_we    = (state_reg == ST_DECIDE) && (cmd_reg == CMD_SET);
    assign cnt_we    = (state_reg == ST_DECIDE) && dec_update;
    assign cnt_wdata = sflags.found ? sat_inc(m_cnt) : COUNT_ONE;

    // entries younger than the touched one (all if it was free) age by one; it becomes 0
    assign rank_we = (state_reg == ST_UPD) && rd_vld_reg && valid_reg[rd_idx_reg];
    always_comb
    begin
        if (rd_idx_reg == tgt_reg)
        begin
            rank_wdata = '0;
        end
        else if (all_reg || (rank_rd < thr_reg))
        begin
            rank_wdata = rank_rd + RW'(1);
        end
        else
        begin
            rank_wdata = rank_rd;
        end
    end

    lfukv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (dec_tgt),
        .wdata (key_reg),
        .raddr (scan_reg[IW-1:0]),
        .rdata (key_rd)
    );

    lfukv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (dec_tgt),
        .wdata (val_reg),
        .raddr (scan_reg[IW-1:0]),
        .rdata (val_rd)
    );

    lfukv_ram #(.WIDTH(COUNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (dec_tgt),
        .wdata (cnt_wdata),
        .raddr (scan_reg[IW-1:0]),
        .rdata (cnt_rd)
    );

    lfukv_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rd_idx_reg),
        .wdata (rank_wdata),
        .raddr (scan_reg[IW-1:0]),
        .rdata (rank_rd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - VAL_W - 1){1'b0}}, out_val_reg, out_hit_reg};

    `LFUKV_ASSERT_IMP(a_pipe_drained, clk, rst_n, state_reg == ST_DECIDE, !rd_vld_reg && scan_reg == CW'(ENTRIES))
    `LFUKV_ASSERT_IMP(a_slot_exists, clk, rst_n, state_reg == ST_DECIDE && cmd_reg == CMD_SET && !sflags.found, sflags.free_found || (sflags.vic_found && full))
    `LFUKV_ASSERT_IMP(a_resp_get_only, clk, rst_n, state_reg == ST_RESP, cmd_reg == CMD_GET)
    `LFUKV_ASSERT_NEXT(a_set_no_result, clk, rst_n, in_beat && s_tuser[0] == CMD_SET, state_reg != ST_RESP)

endmodule

// ----- dv/lfu_cache_checker.sv -----
// Scoreboard for lfu_key_value_cache: keeps a shadow copy of the cache from
// accepted command beats and checks each lookup result beat against it.
// Depends on lfukv_pkg.
module lfu_cache_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [lfukv_pkg::CFG_W-1:0]             cfg_data,   // capacity
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [lfukv_pkg::IN_TDATA_W-1:0]        s_tdata,    // key[31:0], value[63:32]
    input  logic [0:0]                              s_tuser,    // command[0]
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [lfukv_pkg::OUT_TDATA_W-1:0]       m_tdata,    // hit[0], read_value[32:1]
    output int                                      errors,
    output int                                      pending
);

    localparam int NUM_ENTRIES = lfukv_pkg::ENTRIES_DEF;
    localparam int LK_DEPTH    = 16;   // far above the lookups that can be outstanding

    typedef struct packed {
        logic                        hit;
        logic [lfukv_pkg::VAL_W-1:0] value;
    } lookup_t;

    logic                          ent_valid [NUM_ENTRIES];
    logic [lfukv_pkg::KEY_W-1:0]   ent_key   [NUM_ENTRIES];
    logic [lfukv_pkg::VAL_W-1:0]   ent_val   [NUM_ENTRIES];
    logic [lfukv_pkg::COUNT_W-1:0] ent_count [NUM_ENTRIES];
    logic [4:0]                    ent_rank  [NUM_ENTRIES];   // 0 = most recent
    logic [lfukv_pkg::CFG_W-1:0]   capacity;

    // expected lookup results, oldest at lk_rd
    lookup_t lookup_fifo [LK_DEPTH];
    int      lk_wr    = 0;
    int      lk_rd    = 0;
    int      lk_count = 0;
    int      fail_cnt = 0;

    function automatic int find_entry(input logic [lfukv_pkg::KEY_W-1:0] k);
        int i;
        for (i = 0; i < NUM_ENTRIES; i++)
            if (ent_valid[i] && ent_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void touch_entry(input int e);
        int         i;
        logic [4:0] r;
        r = ent_rank[e];
        for (i = 0; i < NUM_ENTRIES; i++)
            if (ent_valid[i] && ent_rank[i] < r)
                ent_rank[i] = ent_rank[i] + 5'd1;
        ent_rank[e] = 5'd0;
        if (ent_count[e] != lfukv_pkg::COUNT_MAX)
            ent_count[e] = ent_count[e] + 16'd1;
    endfunction

    function automatic void insert_entry(input logic [lfukv_pkg::KEY_W-1:0] k,
                                         input logic [lfukv_pkg::VAL_W-1:0] v,
                                         input int cap);
        int         i;
        int         slot;
        int         victim;
        int         used;
        logic [4:0] r;
        slot   = -1;
        victim = -1;
        used   = 0;
        for (i = 0; i < NUM_ENTRIES; i++)
        begin
            if (ent_valid[i])
            begin
                used++;
                // fewest uses first, oldest among equals
                if (victim < 0 || ent_count[i] < ent_count[victim] ||
                    (ent_count[i] == ent_count[victim] && ent_rank[i] > ent_rank[victim]))
                    victim = i;
            end
            else if (slot < 0)
            begin
                slot = i;
            end
        end
        if (used >= cap && victim >= 0)
        begin
            r = ent_rank[victim];
            ent_valid[victim] = 1'b0;
            for (i = 0; i < NUM_ENTRIES; i++)
                if (ent_valid[i] && ent_rank[i] > r)
                    ent_rank[i] = ent_rank[i] - 5'd1;
            slot = victim;
        end
        if (slot < 0)
            return;
        for (i = 0; i < NUM_ENTRIES; i++)
            if (ent_valid[i])
                ent_rank[i] = ent_rank[i] + 5'd1;
        ent_valid[slot] = 1'b1;
        ent_key[slot]   = k;
        ent_val[slot]   = v;
        ent_count[slot] = lfukv_pkg::COUNT_ONE;
        ent_rank[slot]  = 5'd0;
    endfunction

    function automatic void apply_command(input logic cmd,
                                          input logic [lfukv_pkg::KEY_W-1:0] k,
                                          input logic [lfukv_pkg::VAL_W-1:0] v);
        int      eff_cap;
        int      e;
        lookup_t res;
        eff_cap = (capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(capacity);
        if (cmd == lfukv_pkg::CMD_SET)
        begin
            if (eff_cap == 0)
                return;
            e = find_entry(k);
            if (e >= 0)
            begin
                ent_val[e] = v;
                touch_entry(e);
            end
            else
            begin
                insert_entry(k, v, eff_cap);
            end
        end
        else
        begin
            // capacity zero misses even on entries still stored
            e = (eff_cap == 0) ? -1 : find_entry(k);
            if (e < 0)
            begin
                res.hit   = 1'b0;
                res.value = lfukv_pkg::MISS_VALUE;
            end
            else
            begin
                res.hit   = 1'b1;
                res.value = ent_val[e];
                touch_entry(e);
            end
            if (lk_count == LK_DEPTH)
            begin
                $error("too many lookups outstanding: %0d", lk_count);
                fail_cnt++;
            end
            else
            begin
                lookup_fifo[lk_wr] = res;
                lk_wr = (lk_wr + 1) % LK_DEPTH;
                lk_count++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lookup_t want;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                ent_valid[i] = 1'b0;
                ent_key[i]   = '0;
                ent_val[i]   = '0;
                ent_count[i] = '0;
                ent_rank[i]  = '0;
            end
            capacity = lfukv_pkg::CAP_RESET;
            lk_wr    = 0;
            lk_rd    = 0;
            lk_count = 0;
            errors  <= fail_cnt;
            pending <= 0;
        end
        else
        begin
            // results always stem from earlier beats: retire before predicting
            if (m_tvalid && m_tready)
            begin
                if (lk_count == 0)
                begin
                    $error("result beat with no lookup outstanding: hit %0d read_value %0d",
                           m_tdata[0], $signed(m_tdata[32:1]));
                    fail_cnt++;
                end
                else
                begin
                    want = lookup_fifo[lk_rd];
                    lk_rd = (lk_rd + 1) % LK_DEPTH;
                    lk_count--;
                    if (m_tdata[0] !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_tdata[0]);
                        fail_cnt++;
                    end
                    if (m_tdata[32:1] !== want.value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(m_tdata[32:1]));
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            errors  <= fail_cnt;
            pending <= lk_count;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the lfu_key_value_cache bench: clock, reset, command stimulus over
// several capacities, result back-pressure, watchdog and verdict.
// Depends on lfukv_pkg, lfu_cache_checker and the cache RTL.
module testbench;

    localparam int QUIET_LIMIT  = 4000;   // cycles without any beat
    localparam int DRAIN_CYCLES = 64;     // covers a set still in flight
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 10;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [lfukv_pkg::CFG_W-1:0]         cfg_data  = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [lfukv_pkg::IN_TDATA_W-1:0]    s_tdata   = '0;
    logic [0:0]                          s_tuser   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [lfukv_pkg::OUT_TDATA_W-1:0]   m_tdata;

    int   errors;
    int   pending;
    int   quiet     = 0;
    logic calm      = 1'b0;   // no idling on either side
    logic hold_req  = 1'b0;   // asks the receiver for one hold of HOLD_CYCLES

    logic [lfukv_pkg::CFG_W-1:0] phase_caps [NUM_PHASES] =
        '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd2, 5'd8, 5'd16, 5'd3, 5'd12};

    always #4 clk = ~clk;

    lfu_key_value_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lfu_cache_checker cache_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    // optional idle gap, then one command beat held until accepted
    task automatic send_command(input logic cmd,
                                input logic [lfukv_pkg::KEY_W-1:0] k,
                                input logic [lfukv_pkg::VAL_W-1:0] v);
        int n;
        n = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 21)
                n++;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {v, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfukv_pkg::CFG_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result receiver
    initial
    begin : receiver
        logic held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [lfukv_pkg::KEY_W-1:0] key_pool [20];
        logic [lfukv_pkg::KEY_W-1:0] k;
        logic                        cmd;
        int                          phase;
        int                          i;
        int                          eff;
        int                          pool_n;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, extreme keys and values, overwrite
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
        send_command(lfukv_pkg::CMD_SET, 32'h0000_0000, 32'h7FFF_FFFF);
        send_command(lfukv_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        send_command(lfukv_pkg::CMD_SET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_command(lfukv_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_command(lfukv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
        send_command(lfukv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
        send_command(lfukv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
        send_command(lfukv_pkg::CMD_GET, 32'h1234_5678, 32'h0);
        send_command(lfukv_pkg::CMD_SET, 32'h0000_0000, 32'hA5A5_A5A5);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'h0);

        // capacity below the stored count: each insert evicts one victim
        wait_drained();
        write_capacity(5'd2);
        send_command(lfukv_pkg::CMD_SET, 32'h0000_1111, 32'h1);
        send_command(lfukv_pkg::CMD_SET, 32'h0000_2222, 32'h2);
        send_command(lfukv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'h0);

        // capacity zero: stored entries are unreachable, sets do nothing
        wait_drained();
        write_capacity(5'd0);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
        send_command(lfukv_pkg::CMD_SET, 32'h0000_3333, 32'h3);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_3333, 32'h0);

        // capacity above the entry count
        wait_drained();
        write_capacity(5'd31);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
        send_command(lfukv_pkg::CMD_GET, 32'h0000_3333, 32'h0);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            write_capacity(phase_caps[phase]);
            calm   = (phase == 7);
            eff    = (phase_caps[phase] > 16) ? 16 : int'(phase_caps[phase]);
            pool_n = ((eff == 0) ? 4 : eff) + 3;
            for (i = 0; i < pool_n; i++)
                key_pool[i] = $urandom;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 2 && i == 40)
                    hold_req = 1'b1;
                if (phase == 5 && i == 75)
                    wait_drained();
                // skewed pick from a small pool so counts differ; some stray keys
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
                else
                    k = $urandom;
                cmd = ($urandom_range(0, 99) < 55) ? lfukv_pkg::CMD_GET : lfukv_pkg::CMD_SET;
                send_command(cmd, k, $urandom);
            end
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
